FILE: hw/rtl/erp_pkg.sv
// ----------------------------------------------------------------------------
// erp_pkg: shared types and constants for the rotate-about-point block
// Word formats, configuration indexes, trig sequencer states and the
// reciprocal table of the sine and cosine series.
// ----------------------------------------------------------------------------
`default_nettype none

package erp_pkg;

    localparam int TRIG_FRAC_BITS_DEF = 30;

    // Width of a coordinate inside the pipeline, and of a sine or cosine.
    localparam int VW = 35;
    localparam int CW = 32;

    // Series work is done with 31 fraction bits.
    localparam int KFRAC = 31;

    // Degrees times 65536: a full turn and one octant.
    localparam logic signed [26:0] ANG_FULL = 27'sd23592960;
    localparam logic [24:0]        ANG_OCT  = 25'd2949120;

    // round(2^47 * pi / 180), split for two narrow products.
    localparam logic [41:0] DEG_TO_RAD_Q47 = 42'd2456332552788;
    localparam logic [20:0] D2R_LO = DEG_TO_RAD_Q47[20:0];
    localparam logic [20:0] D2R_HI = DEG_TO_RAD_Q47[41:21];

    typedef enum logic [2:0] {
        CFG_ANGLE_X = 3'd0,
        CFG_ANGLE_Y = 3'd1,
        CFG_ANGLE_Z = 3'd2,
        CFG_PIVOT_X = 3'd3,
        CFG_PIVOT_Y = 3'd4,
        CFG_PIVOT_Z = 3'd5
    } cfg_idx_t;

    typedef enum logic [3:0] {
        TS_IDLE,
        TS_REDUCE,
        TS_OCT,
        TS_TH_LO,
        TS_TH_HI,
        TS_THETA,
        TS_X2M,
        TS_X2,
        TS_MUL,
        TS_DIV_LOAD,
        TS_DIV,
        TS_ACC,
        TS_FIN
    } trig_state_t;

    typedef struct packed {
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
    } point_t;

    typedef struct packed {
        logic signed [31:0] rotated_x;
        logic signed [31:0] rotated_y;
        logic signed [31:0] rotated_z;
    } result_t;

    typedef struct packed {
        logic signed [VW-1:0] x;
        logic signed [VW-1:0] y;
        logic signed [VW-1:0] z;
    } vec_t;

    typedef struct packed {
        logic signed [CW-1:0] sn;
        logic signed [CW-1:0] cs;
    } trig_coef_t;

    typedef struct packed {
        logic [31:0] mult;
        logic [5:0]  shift;
    } recip_t;

    // Reciprocal of the divisor of Taylor term k (1 to 6): n(n+1) for sine,
    // (n-1)n for cosine. Every numerator stays below 2^31, so the rounded-up
    // reciprocal and its shift give the exact truncated quotient.
    function automatic recip_t recip_const(input logic [2:0] k, input logic is_cos);
        recip_t rc;
        begin
            rc.mult  = 32'h8000_0000;
            rc.shift = 6'd31;
            unique case (k)
                3'd1:
                begin
                    rc.mult  = is_cos ? 32'd2147483648 : 32'd2863311531;
                    rc.shift = is_cos ? 6'd32 : 6'd34;
                end
                3'd2:
                begin
                    rc.mult  = is_cos ? 32'd2863311531 : 32'd3435973837;
                    rc.shift = is_cos ? 6'd35 : 6'd36;
                end
                3'd3:
                begin
                    rc.mult  = is_cos ? 32'd2290649225 : 32'd3272356036;
                    rc.shift = is_cos ? 6'd36 : 6'd37;
                end
                3'd4:
                begin
                    rc.mult  = is_cos ? 32'd2454267027 : 32'd3817748708;
                    rc.shift = is_cos ? 6'd37 : 6'd38;
                end
                3'd5:
                begin
                    rc.mult  = is_cos ? 32'd3054198967 : 32'd2498890064;
                    rc.shift = 6'd38;
                end
                3'd6:
                begin
                    rc.mult  = is_cos ? 32'd4164816772 : 32'd3524075731;
                    rc.shift = 6'd39;
                end
                default:
                begin
                    rc.mult  = 32'h8000_0000;
                    rc.shift = 6'd31;
                end
            endcase
            return rc;
        end
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/euler_rotate_about_point.sv
// ----------------------------------------------------------------------------
// euler_rotate_about_point: rotation of a point about a pivot, X then Y then Z
// Pivot subtract, three pipelined plane rotations, pivot add and saturation.
//
//   channel   ports                            rule
//   input     start, busy, point               taken when start and !busy
//   result    done, result                     one cycle, no hold-off
//   config    cfg_we, cfg_index, cfg_data      written when cfg_we
//
// One word is accepted per cycle while busy is low; its result passes
// through the eight register stages of the datapath before done marks it
// on the ports.
// After reset and after each angle write, busy stays high while the trig
// sequencer recomputes all three sines and cosines with its shared multiplier,
// which each of the twelve series terms of an axis uses twice. An angle
// write during a pass queues one more pass.
// Pivot writes take effect at once and do not raise busy.
// ----------------------------------------------------------------------------
`default_nettype none

module euler_rotate_about_point
    import erp_pkg::*;
#(
    parameter int TRIG_FRAC_BITS = TRIG_FRAC_BITS_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire point_t      point,
    output logic             done,
    output result_t          result,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);

    localparam int LAT = 8;

    logic signed [25:0] angle_reg [3];
    logic signed [31:0] pivot_reg [3];
    logic               ang_wr;
    logic               accept;
    trig_coef_t         coef [3];

    logic  v0_reg;
    vec_t  vec0_reg;
    logic  vx, vy, vz;
    vec_t  px, py, pz;
    logic  done_reg;
    result_t result_reg, result_next;

    assign ang_wr = cfg_we && (cfg_index == CFG_ANGLE_X || cfg_index == CFG_ANGLE_Y
                               || cfg_index == CFG_ANGLE_Z);
    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                angle_reg[i] <= '0;
                pivot_reg[i] <= '0;
            end
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_ANGLE_X: angle_reg[0] <= cfg_data[25:0];
                CFG_ANGLE_Y: angle_reg[1] <= cfg_data[25:0];
                CFG_ANGLE_Z: angle_reg[2] <= cfg_data[25:0];
                CFG_PIVOT_X: pivot_reg[0] <= cfg_data;
                CFG_PIVOT_Y: pivot_reg[1] <= cfg_data;
                CFG_PIVOT_Z: pivot_reg[2] <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    erp_trig #(
        .TRIG_FRAC_BITS(TRIG_FRAC_BITS)
    ) u_trig (
        .clk    (clk),
        .rst_n  (rst_n),
        .angle  (angle_reg),
        .ang_wr (ang_wr),
        .coef   (coef),
        .busy   (busy)
    );

    // Pivot subtract.
    always_ff @(posedge clk)
    begin
        vec0_reg.x <= VW'(point.point_x) - VW'(pivot_reg[0]);
        vec0_reg.y <= VW'(point.point_y) - VW'(pivot_reg[1]);
        vec0_reg.z <= VW'(point.point_z) - VW'(pivot_reg[2]);
    end

    erp_plane #(.TRIG_FRAC_BITS(TRIG_FRAC_BITS), .AXIS(0)) u_rot_x (
        .clk(clk), .rst_n(rst_n), .in_valid(v0_reg), .in_vec(vec0_reg),
        .coef(coef[0]), .out_valid(vx), .out_vec(px)
    );

    erp_plane #(.TRIG_FRAC_BITS(TRIG_FRAC_BITS), .AXIS(1)) u_rot_y (
        .clk(clk), .rst_n(rst_n), .in_valid(vx), .in_vec(px),
        .coef(coef[1]), .out_valid(vy), .out_vec(py)
    );

    erp_plane #(.TRIG_FRAC_BITS(TRIG_FRAC_BITS), .AXIS(2)) u_rot_z (
        .clk(clk), .rst_n(rst_n), .in_valid(vy), .in_vec(py),
        .coef(coef[2]), .out_valid(vz), .out_vec(pz)
    );

    // Pivot add and saturation to the signed 32-bit range.
    function automatic logic signed [31:0] sat_add(input logic signed [VW-1:0] v,
                                                    input logic signed [31:0] p);
        logic signed [VW:0] s;
        begin
            s = (VW + 1)'(v) + (VW + 1)'(p);
            if (s > (VW + 1)'(32'sh7FFF_FFFF))
                return 32'sh7FFF_FFFF;
            else if (s < -((VW + 1)'(33'sh0_8000_0000)))
                return 32'sh8000_0000;
            else
                return 32'(s);
        end
    endfunction

    always_comb
    begin
        result_next.rotated_x = sat_add(pz.x, pivot_reg[0]);
        result_next.rotated_y = sat_add(pz.y, pivot_reg[1]);
        result_next.rotated_z = sat_add(pz.z, pivot_reg[2]);
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v0_reg   <= accept;
            done_reg <= vz;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, LAT))
        else $error("result word without an accepted input word");

    assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##LAT done)
        else $error("accepted input word produced no result");

    assert property (@(posedge clk) disable iff (!rst_n)
        ang_wr |=> busy)
        else $error("angle write left the block ready");

endmodule

`default_nettype wire

FILE: hw/rtl/erp_trig.sv
// ----------------------------------------------------------------------------
// erp_trig: sine and cosine sequencer
// Recomputes the sine and cosine of all three angles after reset and after
// any angle write, with one shared multiplier that also divides each series
// term by reciprocal multiplication.
// ----------------------------------------------------------------------------
`default_nettype none

module erp_trig
    import erp_pkg::*;
#(
    parameter int TRIG_FRAC_BITS = TRIG_FRAC_BITS_DEF
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic signed [25:0] angle [3],
    input  wire logic               ang_wr,
    output trig_coef_t              coef [3],
    output logic                    busy
);

    localparam int SH = KFRAC - TRIG_FRAC_BITS;
    localparam logic [33:0] RND = 34'd1 << (SH - 1);

    trig_state_t state_reg, state_next;
    logic        dirty_reg, dirty_next;
    logic [1:0]  axis_reg, axis_next;
    logic [24:0] a_reg, a_next;
    logic [2:0]  o_reg, o_next;
    logic [21:0] r_reg, r_next;
    logic [42:0] plo_reg, plo_next;
    logic [63:0] prod_reg, prod_next;
    logic [30:0] theta_reg, theta_next;
    logic [31:0] x2_reg, x2_next;
    logic [31:0] ts_reg, ts_next, tc_reg, tc_next;
    logic signed [33:0] ssum_reg, ssum_next, csum_reg, csum_next;
    logic [2:0]  k_reg, k_next;
    logic        sel_reg, sel_next;
    logic [31:0] num_reg, num_next;
    trig_coef_t  coef_reg [3];
    trig_coef_t  coef_next;

    logic [31:0] mul_a, mul_b;
    logic signed [26:0] ang_ext, ang_red;
    logic [2:0]  oct;
    logic [24:0] oct_base, oct_rem;
    recip_t      rcp;
    logic [31:0] quo;
    logic [33:0] s_clamp, c_clamp, s_rnd, c_rnd;
    logic signed [CW-1:0] s0, c0, st, ct;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            TS_IDLE:     state_next = dirty_reg ? TS_REDUCE : TS_IDLE;
            TS_REDUCE:   state_next = TS_OCT;
            TS_OCT:      state_next = TS_TH_LO;
            TS_TH_LO:    state_next = TS_TH_HI;
            TS_TH_HI:    state_next = TS_THETA;
            TS_THETA:    state_next = TS_X2M;
            TS_X2M:      state_next = TS_X2;
            TS_X2:       state_next = TS_MUL;
            TS_MUL:      state_next = TS_DIV_LOAD;
            TS_DIV_LOAD: state_next = TS_DIV;
            TS_DIV:      state_next = TS_ACC;
            TS_ACC:      state_next = (sel_reg && k_reg == 3'd6) ? TS_FIN : TS_MUL;
            TS_FIN:      state_next = (axis_reg == 2'd2) ? TS_IDLE : TS_REDUCE;
            default:     state_next = TS_IDLE;
        endcase
    end

    // Shared multiplier operands.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        rcp   = recip_const(k_reg, sel_reg);
        unique case (state_reg)
            TS_TH_LO:
            begin
                mul_a = {10'd0, r_reg};
                mul_b = {11'd0, D2R_LO};
            end
            TS_TH_HI:
            begin
                mul_a = {10'd0, r_reg};
                mul_b = {11'd0, D2R_HI};
            end
            TS_X2M:
            begin
                mul_a = {1'b0, theta_reg};
                mul_b = {1'b0, theta_reg};
            end
            TS_MUL:
            begin
                mul_a = sel_reg ? tc_reg : ts_reg;
                mul_b = x2_reg;
            end
            TS_DIV:
            begin
                mul_a = num_reg;
                mul_b = rcp.mult;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Angle reduction into one turn and split into octant and remainder.
    always_comb
    begin
        ang_ext = 27'(angle[axis_reg]);
        if (ang_ext < 0)
        begin
            ang_red = ang_ext + ANG_FULL;
            if (ang_red < 0)
                ang_red = ang_red + ANG_FULL;
        end
        else if (ang_ext >= ANG_FULL)
            ang_red = ang_ext - ANG_FULL;
        else
            ang_red = ang_ext;

        priority if (a_reg >= 25'(7 * ANG_OCT)) oct = 3'd7;
        else if (a_reg >= 25'(6 * ANG_OCT))     oct = 3'd6;
        else if (a_reg >= 25'(5 * ANG_OCT))     oct = 3'd5;
        else if (a_reg >= 25'(4 * ANG_OCT))     oct = 3'd4;
        else if (a_reg >= 25'(3 * ANG_OCT))     oct = 3'd3;
        else if (a_reg >= 25'(2 * ANG_OCT))     oct = 3'd2;
        else if (a_reg >= ANG_OCT)              oct = 3'd1;
        else                                    oct = 3'd0;
        oct_base = 25'(oct * ANG_OCT);
        oct_rem  = a_reg - oct_base;
    end

    // Quotient, rounding and the octant symmetries.
    always_comb
    begin
        quo = 32'(prod_reg >> rcp.shift);

        s_clamp = ssum_reg[33] ? 34'd0 : 34'(ssum_reg);
        c_clamp = csum_reg[33] ? 34'd0 : 34'(csum_reg);
        s_rnd   = (s_clamp + RND) >> SH;
        c_rnd   = (c_clamp + RND) >> SH;
        s0      = CW'(s_rnd);
        c0      = CW'(c_rnd);
        st      = o_reg[0] ? c0 : s0;
        ct      = o_reg[0] ? s0 : c0;
        unique case (o_reg[2:1])
            2'd0:
            begin
                coef_next.sn = st;
                coef_next.cs = ct;
            end
            2'd1:
            begin
                coef_next.sn = ct;
                coef_next.cs = -st;
            end
            2'd2:
            begin
                coef_next.sn = -st;
                coef_next.cs = -ct;
            end
            default:
            begin
                coef_next.sn = -ct;
                coef_next.cs = st;
            end
        endcase
    end

    // Datapath next values.
    always_comb
    begin
        dirty_next = dirty_reg;
        axis_next  = axis_reg;
        a_next     = a_reg;
        o_next     = o_reg;
        r_next     = r_reg;
        plo_next   = plo_reg;
        prod_next  = mul_a * mul_b;
        theta_next = theta_reg;
        x2_next    = x2_reg;
        ts_next    = ts_reg;
        tc_next    = tc_reg;
        ssum_next  = ssum_reg;
        csum_next  = csum_reg;
        k_next     = k_reg;
        sel_next   = sel_reg;
        num_next   = num_reg;

        unique case (state_reg)
            TS_IDLE:
            begin
                if (dirty_reg)
                begin
                    dirty_next = 1'b0;
                    axis_next  = 2'd0;
                end
            end
            TS_REDUCE:
                a_next = ang_red[24:0];
            TS_OCT:
            begin
                o_next = oct;
                r_next = oct[0] ? 22'(ANG_OCT - oct_rem) : oct_rem[21:0];
            end
            TS_TH_HI:
                plo_next = prod_reg[42:0];
            TS_THETA:
                theta_next = 31'(({prod_reg[42:0], 21'd0} + {21'd0, plo_reg}
                                  + 64'h8000_0000) >> 32);
            TS_X2:
            begin
                x2_next   = 32'((prod_reg + 64'h4000_0000) >> KFRAC);
                ts_next   = {1'b0, theta_reg};
                tc_next   = 32'h8000_0000;
                ssum_next = 34'(theta_reg);
                csum_next = 34'sh0_8000_0000;
                k_next    = 3'd1;
                sel_next  = 1'b0;
            end
            TS_DIV_LOAD:
                num_next = prod_reg[62:31];
            TS_ACC:
            begin
                if (!sel_reg)
                begin
                    ts_next   = quo;
                    ssum_next = k_reg[0] ? ssum_reg - $signed({2'b00, quo})
                                         : ssum_reg + $signed({2'b00, quo});
                    sel_next  = 1'b1;
                end
                else
                begin
                    tc_next   = quo;
                    csum_next = k_reg[0] ? csum_reg - $signed({2'b00, quo})
                                         : csum_reg + $signed({2'b00, quo});
                    sel_next  = 1'b0;
                    k_next    = k_reg + 3'd1;
                end
            end
            TS_FIN:
                axis_next = (axis_reg == 2'd2) ? 2'd0 : axis_reg + 2'd1;
            default:
            begin
            end
        endcase

        // A fresh angle write always forces another pass.
        if (ang_wr)
            dirty_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= TS_IDLE;
            dirty_reg <= 1'b1;
            axis_reg  <= 2'd0;
            k_reg     <= 3'd1;
            sel_reg   <= 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                coef_reg[i].sn <= '0;
                coef_reg[i].cs <= CW'(1) <<< TRIG_FRAC_BITS;
            end
        end
        else
        begin
            state_reg <= state_next;
            dirty_reg <= dirty_next;
            axis_reg  <= axis_next;
            k_reg     <= k_next;
            sel_reg   <= sel_next;
            if (state_reg == TS_FIN)
                coef_reg[axis_reg] <= coef_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg     <= a_next;
        o_reg     <= o_next;
        r_reg     <= r_next;
        plo_reg   <= plo_next;
        prod_reg  <= prod_next;
        theta_reg <= theta_next;
        x2_reg    <= x2_next;
        ts_reg    <= ts_next;
        tc_reg    <= tc_next;
        ssum_reg  <= ssum_next;
        csum_reg  <= csum_next;
        num_reg   <= num_next;
    end

    assign coef = coef_reg;
    assign busy = dirty_reg || (state_reg != TS_IDLE);

    assert property (@(posedge clk) disable iff (!rst_n)
        ang_wr |=> busy)
        else $error("angle write did not start a recompute");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == TS_DIV) |=> (state_reg == TS_ACC))
        else $error("reciprocal product was not taken up after the divide step");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == TS_FIN) && (axis_reg == 2'd2) && !dirty_reg && !ang_wr
        |=> !busy)
        else $error("sequencer stayed busy after the last axis");

endmodule

`default_nettype wire

FILE: hw/rtl/erp_plane.sv
// ----------------------------------------------------------------------------
// erp_plane: one plane rotation, two pipeline stages
// Stage one forms the four products, stage two sums, rounds half up and
// drops the fraction bits of the sine and cosine.
// ----------------------------------------------------------------------------
`default_nettype none

module erp_plane
    import erp_pkg::*;
#(
    parameter int TRIG_FRAC_BITS = TRIG_FRAC_BITS_DEF,
    parameter int AXIS           = 0
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    input  wire vec_t       in_vec,
    input  wire trig_coef_t coef,
    output logic            out_valid,
    output vec_t            out_vec
);

    localparam int PW = VW + CW;
    localparam logic signed [PW:0] HALF = (PW + 1)'(1) <<< (TRIG_FRAC_BITS - 1);

    logic signed [VW-1:0] a, b;
    logic signed [PW-1:0] pac_reg, pbs_reg, pas_reg, pbc_reg;
    logic                 v1_reg, v2_reg;
    vec_t                 vec1_reg, vec2_reg, vec2_next;
    logic signed [PW:0]   na, nb;
    logic signed [PW:0]   sa, sb;

    always_comb
    begin
        if (AXIS == 0)
        begin
            a = in_vec.y;
            b = in_vec.z;
        end
        else if (AXIS == 1)
        begin
            a = in_vec.z;
            b = in_vec.x;
        end
        else
        begin
            a = in_vec.x;
            b = in_vec.y;
        end
    end

    always_ff @(posedge clk)
    begin
        pac_reg  <= PW'(a) * PW'(coef.cs);
        pbs_reg  <= PW'(b) * PW'(coef.sn);
        pas_reg  <= PW'(a) * PW'(coef.sn);
        pbc_reg  <= PW'(b) * PW'(coef.cs);
        vec1_reg <= in_vec;
        vec2_reg <= vec2_next;
    end

    always_comb
    begin
        na = (PW + 1)'(pac_reg) - (PW + 1)'(pbs_reg) + HALF;
        nb = (PW + 1)'(pas_reg) + (PW + 1)'(pbc_reg) + HALF;
        sa = na >>> TRIG_FRAC_BITS;
        sb = nb >>> TRIG_FRAC_BITS;
        vec2_next = vec1_reg;
        if (AXIS == 0)
        begin
            vec2_next.y = VW'(sa);
            vec2_next.z = VW'(sb);
        end
        else if (AXIS == 1)
        begin
            vec2_next.z = VW'(sa);
            vec2_next.x = VW'(sb);
        end
        else
        begin
            vec2_next.x = VW'(sa);
            vec2_next.y = VW'(sb);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    assign out_valid = v2_reg;
    assign out_vec   = vec2_reg;

endmodule

`default_nettype wire
